@@ rtl/sts_pkg.sv @@
// Shared types, codes and helper functions of the sorted table search unit.
package sts_pkg;

    localparam int OP_W       = 2;
    localparam int IDX_W      = 8;
    localparam int VAL_W      = 64;
    localparam int KEY_W      = 32;
    localparam int STAT_W     = 2;
    localparam int POS_W      = 9;
    localparam int LEN_W      = 9;
    localparam int WSEL_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam int S_TDATA_W  = 112;
    localparam int M_TDATA_W  = 16;

    localparam logic [OP_W-1:0] OP_LOAD     = 2'd0;
    localparam logic [OP_W-1:0] OP_EXACT    = 2'd1;
    localparam logic [OP_W-1:0] OP_INTERVAL = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_SEL    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 1'd1;

    localparam logic [WSEL_W-1:0] WSEL_8  = 2'd0;
    localparam logic [WSEL_W-1:0] WSEL_16 = 2'd1;
    localparam logic [WSEL_W-1:0] WSEL_32 = 2'd2;

    typedef enum logic [1:0] {
        ADDR_FIRST,
        ADDR_LAST,
        ADDR_MID
    } t_addr_sel;

    typedef enum logic [2:0] {
        BND_HOLD,
        BND_INIT_EXACT,
        BND_INIT_INTERVAL,
        BND_STEP_EXACT,
        BND_STEP_INTERVAL
    } t_bnd;

    typedef enum logic [2:0] {
        RES_OK_ZERO,
        RES_MISS,
        RES_EMPTY,
        RES_LAST,
        RES_LEN,
        RES_MID,
        RES_LO
    } t_res;

    typedef struct packed {
        logic      ram_we;
        logic      key_ld;
        t_addr_sel addr_sel;
        logic      cap_first;
        logic      asc_live;
        t_bnd      bnd;
        logic      res_ld;
        t_res      res_sel;
        logic      out_ld;
    } t_cmd;

    typedef struct packed {
        logic len_zero;
        logic len_lt3;
        logic f_eq;
        logic f_before_k;
        logic k_before_f;
        logic e_eq;
        logic e_before_k;
        logic loop_ok_exact;
        logic loop_ok_interval;
    } t_stat;

    function automatic logic [VAL_W-1:0] width_mask(input logic [WSEL_W-1:0] sel);
        logic [VAL_W-1:0] m;
        case (sel)
            WSEL_8:  m = 64'h0000_0000_0000_00FF;
            WSEL_16: m = 64'h0000_0000_0000_FFFF;
            WSEL_32: m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/sts_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module sts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sts_dp.sv @@
// Datapath of the sorted table search unit: table memory, bounds, compares and results.
module sts_dp import sts_pkg::*; #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [IDX_W-1:0]      i_entry_index,
    input  logic [VAL_W-1:0]      i_entry_value,
    input  logic [KEY_W-1:0]      i_search_key,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic [STAT_W-1:0]     o_status,
    output logic [POS_W-1:0]      o_position
);

    localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LEN_CAP = (TABLE_DEPTH > 511) ? 511 : TABLE_DEPTH;

    logic [WSEL_W-1:0] r_width_sel;
    logic [LEN_W-1:0]  r_table_len;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_first;
    logic              r_f_lt, r_f_gt, r_f_eq;
    logic              r_asc;
    logic [POS_W-1:0]  r_lo, r_hi, r_mid;
    logic [STAT_W-1:0] r_res_status, r_out_status;
    logic [POS_W-1:0]  r_res_pos, r_out_pos;

    logic [LEN_W-1:0]  len_used;
    logic [POS_W-1:0]  last_idx;
    logic [VAL_W-1:0]  mask;
    logic [VAL_W-1:0]  key64;
    logic [VAL_W-1:0]  ram_q;
    logic [VAL_W-1:0]  entry;
    logic              e_lt, e_gt, e_eq, first_lt_e, asc_now;
    logic [POS_W-1:0]  mid_c;
    logic [AW-1:0]     raddr;
    logic              ld_in_range;
    logic [STAT_W-1:0] n_res_status;
    logic [POS_W-1:0]  n_res_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_sel <= '0;
            r_table_len <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WIDTH_SEL:    r_width_sel <= i_cfg_wdata[WSEL_W-1:0];
                CFG_TABLE_LENGTH: r_table_len <= i_cfg_wdata[LEN_W-1:0];
                default:          r_width_sel <= r_width_sel;
            endcase
        end
    end

    assign len_used = (r_table_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : r_table_len;
    assign last_idx = len_used - 9'd1;
    assign mask     = width_mask(r_width_sel);
    assign key64    = {{(VAL_W-KEY_W){1'b0}}, r_key};

    assign ld_in_range = (32'(i_entry_index) < 32'(TABLE_DEPTH));
    assign mid_c       = POS_W'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);

    always_comb begin
        case (i_cmd.addr_sel)
            ADDR_LAST: raddr = AW'(last_idx);
            ADDR_MID:  raddr = AW'(mid_c);
            default:   raddr = '0;
        endcase
    end

    sts_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we && ld_in_range),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata (i_entry_value & mask),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    assign entry      = ram_q & mask;
    assign e_lt       = entry < key64;
    assign e_gt       = entry > key64;
    assign e_eq       = entry == key64;
    assign first_lt_e = r_first < entry;
    assign asc_now    = i_cmd.asc_live ? first_lt_e : r_asc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_ld) begin
            r_key <= i_search_key;
        end
        if (i_cmd.cap_first) begin
            r_first <= entry;
            r_f_lt  <= e_lt;
            r_f_gt  <= e_gt;
            r_f_eq  <= e_eq;
        end
        if (i_cmd.asc_live) begin
            r_asc <= first_lt_e;
        end
        if (i_cmd.addr_sel == ADDR_MID) begin
            r_mid <= mid_c;
        end
        case (i_cmd.bnd)
            BND_INIT_EXACT: begin
                r_lo <= '0;
                r_hi <= last_idx;
            end
            BND_INIT_INTERVAL: begin
                r_lo <= 9'd1;
                r_hi <= last_idx;
            end
            BND_STEP_EXACT: begin
                if (o_stat.e_before_k) begin
                    r_lo <= r_mid;
                end else begin
                    r_hi <= r_mid;
                end
            end
            BND_STEP_INTERVAL: begin
                if (o_stat.e_before_k) begin
                    r_lo <= r_mid + 9'd1;
                end else begin
                    r_hi <= r_mid;
                end
            end
            default: r_lo <= r_lo;
        endcase
    end

    always_comb begin
        n_res_status = ST_OK;
        n_res_pos    = '0;
        case (i_cmd.res_sel)
            RES_MISS:  n_res_status = ST_MISS;
            RES_EMPTY: n_res_status = ST_EMPTY;
            RES_LAST:  n_res_pos    = last_idx;
            RES_LEN:   n_res_pos    = len_used;
            RES_MID:   n_res_pos    = r_mid;
            RES_LO:    n_res_pos    = r_lo;
            default:   n_res_pos    = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ld) begin
            r_res_status <= n_res_status;
            r_res_pos    <= n_res_pos;
        end
        if (i_cmd.out_ld) begin
            r_out_status <= r_res_status;
            r_out_pos    <= r_res_pos;
        end
    end

    always_comb begin
        o_stat.len_zero         = (len_used == '0);
        o_stat.len_lt3          = (len_used < 9'd3);
        o_stat.f_eq             = r_f_eq;
        o_stat.f_before_k       = asc_now ? r_f_lt : r_f_gt;
        o_stat.k_before_f       = asc_now ? r_f_gt : r_f_lt;
        o_stat.e_eq             = e_eq;
        o_stat.e_before_k       = asc_now ? e_lt : e_gt;
        o_stat.loop_ok_exact    = (({1'b0, r_lo} + 10'd2) <= {1'b0, r_hi});
        o_stat.loop_ok_interval = (r_lo < r_hi);
    end

    assign o_status   = r_out_status;
    assign o_position = r_out_pos;

endmodule

@@ rtl/sts_ctrl.sv @@
// Controller state machine of the sorted table search unit.
module sts_ctrl import sts_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic [OP_W-1:0] i_op,
    input  logic            i_m_tready,
    input  t_stat           i_stat,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    output t_cmd            o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_RD_FIRST = 7'b0000010,
        S_RD_LAST  = 7'b0000100,
        S_END_CHK  = 7'b0001000,
        S_LOOP     = 7'b0010000,
        S_PROBE    = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_exact, n_exact;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state         = r_state;
        n_exact         = r_exact;
        o_cmd           = '0;
        o_cmd.addr_sel  = ADDR_FIRST;
        o_cmd.bnd       = BND_HOLD;
        o_cmd.res_sel   = RES_OK_ZERO;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.key_ld = 1'b1;
                    case (i_op)
                        OP_LOAD: begin
                            o_cmd.ram_we = 1'b1;
                            o_cmd.res_ld = 1'b1;
                            n_state      = S_DONE;
                        end
                        OP_EXACT, OP_INTERVAL: begin
                            n_exact = (i_op == OP_EXACT);
                            if (i_stat.len_zero) begin
                                o_cmd.res_ld  = 1'b1;
                                o_cmd.res_sel = RES_EMPTY;
                                n_state       = S_DONE;
                            end else begin
                                n_state = S_RD_FIRST;
                            end
                        end
                        default: begin
                            o_cmd.res_ld = 1'b1;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end
            S_RD_FIRST: begin
                o_cmd.addr_sel = ADDR_FIRST;
                n_state        = S_RD_LAST;
            end
            S_RD_LAST: begin
                o_cmd.addr_sel  = ADDR_LAST;
                o_cmd.cap_first = 1'b1;
                n_state         = S_END_CHK;
            end
            S_END_CHK: begin
                o_cmd.asc_live = 1'b1;
                o_cmd.res_ld   = 1'b1;
                n_state        = S_DONE;
                if (r_exact) begin
                    if (!i_stat.len_lt3 && (i_stat.k_before_f || i_stat.e_before_k)) begin
                        o_cmd.res_sel = RES_MISS;
                    end else if (i_stat.f_eq) begin
                        o_cmd.res_sel = RES_OK_ZERO;
                    end else if (i_stat.e_eq) begin
                        o_cmd.res_sel = RES_LAST;
                    end else if (i_stat.len_lt3) begin
                        o_cmd.res_sel = RES_MISS;
                    end else begin
                        o_cmd.res_ld = 1'b0;
                        o_cmd.bnd    = BND_INIT_EXACT;
                        n_state      = S_LOOP;
                    end
                end else begin
                    if (!i_stat.f_before_k) begin
                        o_cmd.res_sel = RES_OK_ZERO;
                    end else if (i_stat.e_before_k) begin
                        o_cmd.res_sel = RES_LEN;
                    end else begin
                        o_cmd.res_ld = 1'b0;
                        o_cmd.bnd    = BND_INIT_INTERVAL;
                        n_state      = S_LOOP;
                    end
                end
            end
            S_LOOP: begin
                if (r_exact ? i_stat.loop_ok_exact : i_stat.loop_ok_interval) begin
                    o_cmd.addr_sel = ADDR_MID;
                    n_state        = S_PROBE;
                end else begin
                    o_cmd.res_ld  = 1'b1;
                    o_cmd.res_sel = r_exact ? RES_MISS : RES_LO;
                    n_state       = S_DONE;
                end
            end
            S_PROBE: begin
                if (r_exact && i_stat.e_eq) begin
                    o_cmd.res_ld  = 1'b1;
                    o_cmd.res_sel = RES_MID;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.bnd = r_exact ? BND_STEP_EXACT : BND_STEP_INTERVAL;
                    n_state   = S_LOOP;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_exact     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_exact <= n_exact;
            if (o_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

endmodule

@@ rtl/sorted_table_search_unit.sv @@
// Top level of the sorted table search unit.
// A table of up to TABLE_DEPTH unsigned entries is loaded one entry per transaction and
// searched by exact-match or insertion-position queries against a 32-bit key. A load, or
// the unused op, goes straight to the done state, where its result moves to the output
// register once the output is free, and the unit returns to idle for the next transaction.
// A query on a non-empty table reads its first and last entries, which S_END_CHK checks;
// if that does not settle it, k binary-search probes follow, with k at most about log2
// of the table length (eight for 256 entries), and an exact probe that hits ends
// the search. Each probe passes through S_LOOP, which issues the read, and S_PROBE, as
// the table memory has a registered read port and the next probe address depends on the
// compare. One item is worked on at a time; the finished result waits in an output
// register while the next transaction is accepted. Unloaded entries read back undefined.
module sorted_table_search_unit import sts_pkg::*; #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // op, entry_index, entry_value, search_key from bit 0 up, zero padded.
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status, position from bit 0 up, zero padded.
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);

    t_cmd              cmd;
    t_stat             stat;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;

    sts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_op       (s_axis_tdata[1:0]),
        .i_m_tready (m_axis_tready),
        .i_stat     (stat),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_cmd      (cmd)
    );

    sts_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_entry_index (s_axis_tdata[9:2]),
        .i_entry_value (s_axis_tdata[73:10]),
        .i_search_key  (s_axis_tdata[105:74]),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_status      (status),
        .o_position    (position)
    );

    assign m_axis_tdata = {5'd0, position, status};

endmodule

@@ rtl/sts_checker.sv @@
// Port-level checker of the sorted table search unit and its bind statement.
module sts_checker import sts_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Result transaction dropped before it was taken.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == ST_OK || m_axis_tdata[1:0] == ST_MISS
                           || m_axis_tdata[1:0] == ST_EMPTY))
        else $error("Result carries an undefined status code.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[10:2] == '0)
        else $error("Failed query reports a nonzero position.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Input accepted while the previous transaction is still in work.");

endmodule

bind sorted_table_search_unit sts_checker u_sts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
